// ===== hw/rtl/swr_pkg.sv =====
`timescale 1ns / 1ps

package swr_pkg;

    // input event kinds
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result event kinds
    localparam logic [2:0] EV_SEND         = 3'd0;
    localparam logic [2:0] EV_ACK_OK       = 3'd1;
    localparam logic [2:0] EV_ACK_UNKNOWN  = 3'd2;
    localparam logic [2:0] EV_ACK_TIMEOUT  = 3'd3;
    localparam logic [2:0] EV_CONNECTED    = 3'd4;
    localparam logic [2:0] EV_DISCONNECTED = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTO_VERSION = 8'd3;
    localparam int unsigned CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd3;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;
    localparam logic [7:0]  RST_MAX_FAIL      = 8'd1;
    localparam logic [15:0] RST_PROTO_VERSION = 16'd0;

    // one result item
    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] id;
        logic [31:0] seq;
        logic [15:0] ver;
        logic        last;
    } t_result;

    // results produced by one accepted input, pushed into the output queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result mk_res(logic [2:0] ev, logic [31:0] id,
                                       logic [31:0] seq, logic [15:0] ver);
        t_result r;
        r.ev   = ev;
        r.id   = id;
        r.seq  = seq;
        r.ver  = ver;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/stop_and_wait_request_client.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: msg_id, ack_seq; tuser: cmd, rx_failed
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: out_id, out_seq, out_version;
//                                                      tuser: event_res; tlast: is_last
// cfg       in         i_cfg_we (no wait)              index i_cfg_index, data i_cfg_data
//
// one input transaction per cycle while s_axis_tready is high; the protocol step is done
// in the accepting cycle and its results, none, one or two, enter a small result queue
// and are registered in its storage before m_axis shows them
// s_axis_tready is high while the queue has room for two results
// synchronous active-low reset: link down, idle, configuration at its defaults
// output stalls are absorbed by the queue; input is held off only when it is nearly full

module stop_and_wait_request_client
    import swr_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = 4
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input events
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // msg_id [31:0], ack_seq [63:32]
    input  logic [2:0]            s_axis_tuser,  // cmd [1:0], rx_failed [2]
    // result events
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,  // out_id [31:0], out_seq [63:32],
                                                 // out_version [79:64]
    output logic [2:0]            m_axis_tuser,  // event_res [2:0]
    output logic                  m_axis_tlast
);

    logic    w_room;
    logic    w_accept;
    t_push   w_push;
    t_result w_res;

    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && w_room;

    // protocol state and result generation
    swr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_cmd       (s_axis_tuser[1:0]),
        .i_msg_id    (s_axis_tdata[31:0]),
        .i_ack_seq   (s_axis_tdata[63:32]),
        .i_rx_failed (s_axis_tuser[2]),
        .o_push      (w_push)
    );

    // result queue
    swr_ofifo #(
        .DEPTH (OUT_DEPTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res),
        .i_pop   (m_axis_tready)
    );

    assign m_axis_tdata = {w_res.ver, w_res.seq, w_res.id};
    assign m_axis_tuser = w_res.ev;
    assign m_axis_tlast = w_res.last;

endmodule

// ===== hw/rtl/swr_core.sv =====
`timescale 1ns / 1ps

module swr_core
    import swr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                 i_accept,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_msg_id,
    input  logic [31:0]          i_ack_seq,
    input  logic                 i_rx_failed,
    output t_push                o_push
);

    logic [7:0]  r_retry_limit;
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_max_fail;
    logic [15:0] r_proto_version;

    logic        r_waiting_ack,  n_waiting_ack;
    logic [31:0] r_next_seq,     n_next_seq;
    logic [31:0] r_pending_id,   n_pending_id;
    logic [31:0] r_pending_seq,  n_pending_seq;
    logic [15:0] r_pending_ver,  n_pending_ver;
    logic [7:0]  r_retry_count,  n_retry_count;
    logic [7:0]  r_fail_count,   n_fail_count;
    logic        r_link_up,      n_link_up;
    logic [15:0] r_timer_left,   n_timer_left;
    logic        r_timer_running, n_timer_running;

    logic [7:0]  w_retry_inc;
    logic [7:0]  w_fail_inc;
    t_push       w_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit   <= RST_RETRY_LIMIT;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
            r_max_fail      <= RST_MAX_FAIL;
            r_proto_version <= RST_PROTO_VERSION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[7:0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                REG_MAX_FAIL:      r_max_fail      <= i_cfg_data[7:0];
                REG_PROTO_VERSION: r_proto_version <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_retry_inc = r_retry_count + 8'd1;
    assign w_fail_inc  = (r_fail_count == 8'hFF) ? r_fail_count : r_fail_count + 8'd1;

    // protocol step for one accepted transaction
    always_comb begin
        n_waiting_ack   = r_waiting_ack;
        n_next_seq      = r_next_seq;
        n_pending_id    = r_pending_id;
        n_pending_seq   = r_pending_seq;
        n_pending_ver   = r_pending_ver;
        n_retry_count   = r_retry_count;
        n_fail_count    = r_fail_count;
        n_link_up       = r_link_up;
        n_timer_left    = r_timer_left;
        n_timer_running = r_timer_running;
        w_push.cnt      = 2'd0;
        w_push.res0     = mk_res(EV_SEND, 32'd0, 32'd0, 16'd0);
        w_push.res1     = mk_res(EV_SEND, 32'd0, 32'd0, 16'd0);

        if (i_accept) begin
            case (i_cmd)
                CMD_SEND: begin
                    if (!r_waiting_ack) begin
                        n_pending_id    = i_msg_id;
                        n_pending_seq   = r_next_seq;
                        n_pending_ver   = r_proto_version;
                        w_push.res0     = mk_res(EV_SEND, i_msg_id, r_next_seq,
                                                 r_proto_version);
                        w_push.cnt      = 2'd1;
                        n_next_seq      = r_next_seq + 32'd1;
                        n_waiting_ack   = 1'b1;
                        n_retry_count   = 8'd0;
                        n_timer_left    = r_timeout_ticks;
                        n_timer_running = 1'b1;
                    end
                end
                CMD_ACK: begin
                    if (r_waiting_ack) begin
                        n_waiting_ack = 1'b0;
                        if (!i_rx_failed) begin
                            n_timer_running = 1'b0;
                            if (i_msg_id == r_pending_id && i_ack_seq == r_pending_seq) begin
                                n_fail_count = 8'd0;
                                n_link_up    = 1'b1;
                                if (!r_link_up) begin
                                    w_push.res0 = mk_res(EV_CONNECTED, i_msg_id,
                                                         i_ack_seq, 16'd0);
                                    w_push.res1 = mk_res(EV_ACK_OK, i_msg_id,
                                                         i_ack_seq, 16'd0);
                                    w_push.cnt  = 2'd2;
                                end else begin
                                    w_push.res0 = mk_res(EV_ACK_OK, i_msg_id,
                                                         i_ack_seq, 16'd0);
                                    w_push.cnt  = 2'd1;
                                end
                            end else begin
                                w_push.res0 = mk_res(EV_ACK_UNKNOWN, i_msg_id,
                                                     i_ack_seq, 16'd0);
                                w_push.cnt  = 2'd1;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_timer_running) begin
                        if (r_timer_left > 16'd1) begin
                            n_timer_left = r_timer_left - 16'd1;
                        end else if (w_retry_inc < r_retry_limit) begin
                            // resend the stored request and restart the timer
                            n_retry_count   = w_retry_inc;
                            n_timer_left    = r_timeout_ticks;
                            n_timer_running = 1'b1;
                            w_push.res0     = mk_res(EV_SEND, r_pending_id,
                                                     r_pending_seq, r_pending_ver);
                            w_push.cnt      = 2'd1;
                        end else begin
                            // abandon the request
                            n_timer_left    = 16'd0;
                            n_timer_running = 1'b0;
                            n_retry_count   = 8'd0;
                            n_waiting_ack   = 1'b0;
                            n_fail_count    = w_fail_inc;
                            if (w_fail_inc >= r_max_fail) begin
                                n_link_up = 1'b0;
                            end
                            if (w_fail_inc >= r_max_fail && r_link_up) begin
                                w_push.res0 = mk_res(EV_DISCONNECTED, r_pending_id,
                                                     r_pending_seq, 16'd0);
                                w_push.res1 = mk_res(EV_ACK_TIMEOUT, r_pending_id,
                                                     r_pending_seq, 16'd0);
                                w_push.cnt  = 2'd2;
                            end else begin
                                w_push.res0 = mk_res(EV_ACK_TIMEOUT, r_pending_id,
                                                     r_pending_seq, 16'd0);
                                w_push.cnt  = 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // mark the final result of this transaction
        w_push.res0.last = (w_push.cnt == 2'd1);
        w_push.res1.last = (w_push.cnt == 2'd2);
    end

    // protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting_ack   <= 1'b0;
            r_next_seq      <= 32'd0;
            r_pending_id    <= 32'd0;
            r_pending_seq   <= 32'd0;
            r_pending_ver   <= 16'd0;
            r_retry_count   <= 8'd0;
            r_fail_count    <= 8'd0;
            r_link_up       <= 1'b0;
            r_timer_left    <= 16'd0;
            r_timer_running <= 1'b0;
        end else begin
            r_waiting_ack   <= n_waiting_ack;
            r_next_seq      <= n_next_seq;
            r_pending_id    <= n_pending_id;
            r_pending_seq   <= n_pending_seq;
            r_pending_ver   <= n_pending_ver;
            r_retry_count   <= n_retry_count;
            r_fail_count    <= n_fail_count;
            r_link_up       <= n_link_up;
            r_timer_left    <= n_timer_left;
            r_timer_running <= n_timer_running;
        end
    end

    assign o_push = w_push;

    // a request is outstanding only while the timer runs
    a_wait_has_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting_ack |-> r_timer_running)
        else $error("waiting for ack without a running timer");

    // the link only comes up through an accepted ack
    a_link_up_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_link_up) |-> $past(i_accept) && $past(i_cmd) == CMD_ACK)
        else $error("link came up without an ack");

    // the sequence number only moves on a request that was sent
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_next_seq) |-> $past(r_waiting_ack) == 1'b0 && r_waiting_ack)
        else $error("sequence number moved without a new request");

endmodule

// ===== hw/rtl/swr_ofifo.sv =====
`timescale 1ns / 1ps

module swr_ofifo
    import swr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_pop     = i_pop && (r_count != '0);
    assign w_wr_ptr1 = ptr_inc(r_wr_ptr);

    // pointer and fill count update
    always_comb begin
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        case (i_push.cnt)
            2'd1:    n_wr_ptr = w_wr_ptr1;
            2'd2:    n_wr_ptr = ptr_inc(w_wr_ptr1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    // room is kept for the largest burst one transaction can cause
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> r_count <= CNT_W'(DEPTH - 2))
        else $error("results pushed without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with pointers apart");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import swr_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMED_ROWS_FROM = 8;

    localparam logic [1:0]           CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'hFF;
    localparam logic [15:0]          DIR_VERSION = 16'hC3A5;
    localparam t_result              NO_EVENT    = '0;

    // one input event as offered on s_axis
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [31:0] seq;
        logic        failed;
    } t_event_in;

    // one directed stimulus row, results typed in where obvious
    typedef struct {
        t_event_in ev;
        bit        typed;
        int        n;
        t_result   r0;
        t_result   r1;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // msg_id [31:0], ack_seq [63:32]
    logic [2:0]            s_axis_tuser = '0;   // cmd [1:0], rx_failed [2]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;        // out_id [31:0], out_seq [63:32],
                                                // out_version [79:64]
    logic [2:0]            m_axis_tuser;        // event_res [2:0]
    logic                  m_axis_tlast;

    // client model: configuration copy
    bit [7:0]  cfg_retry_limit = RST_RETRY_LIMIT;
    bit [15:0] cfg_timeout     = RST_TIMEOUT_TICKS;
    bit [7:0]  cfg_max_fail    = RST_MAX_FAIL;
    bit [15:0] cfg_version     = RST_PROTO_VERSION;

    // client model: protocol state
    bit        awaiting_ack;
    bit [31:0] seq_counter;
    bit [31:0] req_id;
    bit [31:0] req_seq;
    bit [15:0] req_version;
    bit [7:0]  retries;
    bit [7:0]  failures;
    bit        link_is_up;
    bit [15:0] ticks_left;
    bit        timer_on;

    // results of the latest model step
    t_result   step_res [2];
    int        step_n;

    t_result   expected_events [$];
    t_row      directed_rows [$];
    int        error_count;
    int        sent_items;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_requests;
    int        stall_served;
    int        hold_left;
    int        quiet_cycles;

    stop_and_wait_request_client u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result make_event(logic [2:0] ev, logic [31:0] id,
                                           logic [31:0] seq, logic [15:0] ver,
                                           logic last);
        t_result r;
        r.ev   = ev;
        r.id   = id;
        r.seq  = seq;
        r.ver  = ver;
        r.last = last;
        return r;
    endfunction

    function automatic t_event_in make_input(logic [1:0] cmd, logic [31:0] id,
                                             logic [31:0] seq, logic failed);
        t_event_in e;
        e.cmd    = cmd;
        e.id     = id;
        e.seq    = seq;
        e.failed = failed;
        return e;
    endfunction

    function automatic void add_result(t_result r);
        step_res[step_n] = r;
        step_n++;
    endfunction

    // one protocol step of the client, results left in step_res
    function automatic void client_step(t_event_in e);
        step_n      = 0;
        case (e.cmd)
            CMD_SEND: begin
                if (!awaiting_ack) begin
                    req_id       = e.id;
                    req_seq      = seq_counter;
                    req_version  = cfg_version;
                    add_result(make_event(EV_SEND, req_id, req_seq, req_version, 1'b0));
                    seq_counter  = seq_counter + 32'd1;
                    awaiting_ack = 1'b1;
                    retries      = '0;
                    ticks_left   = cfg_timeout;
                    timer_on     = 1'b1;
                end
            end
            CMD_ACK: begin
                if (awaiting_ack) begin
                    awaiting_ack = 1'b0;
                    // a failed read leaves the timer running
                    if (!e.failed) begin
                        timer_on = 1'b0;
                        if (e.id == req_id && e.seq == req_seq) begin
                            failures = '0;
                            if (!link_is_up)
                                add_result(make_event(EV_CONNECTED, e.id, e.seq, '0, 1'b0));
                            link_is_up = 1'b1;
                            add_result(make_event(EV_ACK_OK, e.id, e.seq, '0, 1'b0));
                        end else begin
                            add_result(make_event(EV_ACK_UNKNOWN, e.id, e.seq, '0, 1'b0));
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (timer_on) begin
                    if (ticks_left > 1) begin
                        ticks_left = ticks_left - 16'd1;
                    end else begin
                        ticks_left = '0;
                        timer_on   = 1'b0;
                        retries    = retries + 8'd1;
                        if (retries < cfg_retry_limit) begin
                            // resend the stored request
                            add_result(make_event(EV_SEND, req_id, req_seq, req_version,
                                                  1'b0));
                            ticks_left = cfg_timeout;
                            timer_on   = 1'b1;
                        end else begin
                            // give up on this request
                            retries      = '0;
                            awaiting_ack = 1'b0;
                            if (failures != 8'hFF)
                                failures = failures + 8'd1;
                            if (failures >= cfg_max_fail) begin
                                if (link_is_up)
                                    add_result(make_event(EV_DISCONNECTED, req_id, req_seq,
                                                          '0, 1'b0));
                                link_is_up = 1'b0;
                            end
                            add_result(make_event(EV_ACK_TIMEOUT, req_id, req_seq, '0, 1'b0));
                        end
                    end
                end
            end
            default: ;
        endcase
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
    endfunction

    function automatic logic [31:0] random_id();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random event, mostly well-formed exchanges around the pending request
    function automatic t_event_in pick_event();
        t_event_in   e;
        int unsigned roll;
        e.id     = random_id();
        e.seq    = $urandom;
        e.failed = 1'($urandom_range(1));
        roll     = $urandom_range(99);
        if (awaiting_ack) begin
            if (roll < 30) begin
                e = make_input(CMD_ACK, req_id, req_seq, 1'b0);
            end else if (roll < 40) begin
                e = make_input(CMD_ACK, req_id, req_seq, 1'b0);
                if ($urandom_range(1))
                    e.id = e.id ^ (32'd1 << $urandom_range(31));
                else
                    e.seq = e.seq ^ (32'd1 << $urandom_range(31));
            end else if (roll < 48) begin
                e.cmd    = CMD_ACK;
                e.failed = 1'b1;
            end else if (roll < 88) begin
                e.cmd = CMD_TICK;
            end else if (roll < 95) begin
                e.cmd = CMD_SEND;
            end else begin
                e.cmd = CMD_UNUSED;
            end
        end else begin
            if (roll < 50)
                e.cmd = CMD_SEND;
            else if (roll < 62)
                e.cmd = CMD_ACK;
            else if (roll < 95)
                e.cmd = CMD_TICK;
            else
                e.cmd = CMD_UNUSED;
        end
        return e;
    endfunction

    function automatic void add_row(t_event_in e, bit typed, int n, t_result r0,
                                    t_result r1);
        t_row row;
        row.ev    = e;
        row.typed = typed;
        row.n     = n;
        row.r0    = r0;
        row.r1    = r1;
        directed_rows.push_back(row);
    endfunction

    // offer one event until its transaction completes, then record what it causes
    task automatic offer_event(input t_event_in e, input bit typed, input int n,
                               input t_result r0, input t_result r1);
        int i;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e.seq, e.id};
        s_axis_tuser  <= {e.failed, e.cmd};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        client_step(e);
        if (typed) begin
            if (n > 0)
                expected_events.push_back(r0);
            if (n > 1)
                expected_events.push_back(r1);
        end else begin
            for (i = 0; i < step_n; i++)
                expected_events.push_back(step_res[i]);
        end
        sent_items++;
    endtask

    // let the block drain before touching its registers
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_RETRY_LIMIT:   cfg_retry_limit = data[7:0];
            REG_TIMEOUT_TICKS: cfg_timeout     = data;
            REG_MAX_FAIL:      cfg_max_fail    = data[7:0];
            REG_PROTO_VERSION: cfg_version     = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] retry, input logic [15:0] timeout,
                                input logic [7:0] max_fail, input logic [15:0] version);
        write_reg(REG_RETRY_LIMIT, {8'h00, retry});
        write_reg(REG_TIMEOUT_TICKS, timeout);
        write_reg(REG_MAX_FAIL, {8'h00, max_fail});
        write_reg(REG_PROTO_VERSION, version);
        // unmapped index must change nothing
        write_reg(REG_UNUSED, ~version);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] retry, input logic [15:0] timeout,
                             input logic [7:0] max_fail, input logic [15:0] version,
                             input int send_pct, input int recv_pct, input int items,
                             input bit with_hold);
        int start_count;
        wait_quiet();
        apply_config(retry, timeout, max_fail, version);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (with_hold)
            stall_requests++;
        start_count = sent_items;
        while (sent_items - start_count < items)
            offer_event(pick_event(), 1'b0, 0, NO_EVENT, NO_EVENT);
    endtask

    // result side: ready pattern, long hold-offs and checking
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ($isunknown(m_axis_tvalid)) begin
                $display("%0t: m_axis_tvalid unknown after reset", $time);
                error_count++;
            end else if (m_axis_tvalid && m_axis_tready) begin
                got.ev   = m_axis_tuser;
                got.id   = m_axis_tdata[31:0];
                got.seq  = m_axis_tdata[63:32];
                got.ver  = m_axis_tdata[79:64];
                got.last = m_axis_tlast;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result ev=%0d id=%h seq=%h ver=%h last=%b",
                             $time, got.ev, got.id, got.seq, got.ver, got.last);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.ev !== want.ev || got.id !== want.id || got.seq !== want.seq ||
                        got.ver !== want.ver || got.last !== want.last) begin
                        $display("%0t: result mismatch, expected ev=%0d id=%h seq=%h ver=%h last=%b",
                                 $time, want.ev, want.id, want.seq, want.ver, want.last);
                        $display("%0t:                  actual ev=%0d id=%h seq=%h ver=%h last=%b",
                                 $time, got.ev, got.id, got.seq, got.ver, got.last);
                        error_count++;
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_requests != stall_served) begin
            stall_served++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("stop_and_wait_request_client test failed");
                $finish;
            end
        end
    end

    initial begin
        int        i;
        t_row      row;
        t_event_in e;

        // after reset: defaults, dropped events, first exchange
        add_row(make_input(CMD_ACK, 32'h0, 32'h0, 1'b0), 1'b1, 0, NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b1, 0, NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b1, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_SEND, 32'hFFFF_FFFF, 32'h0, 1'b0), 1'b1, 1,
                make_event(EV_SEND, 32'hFFFF_FFFF, 32'd0, 16'h0, 1'b1), NO_EVENT);
        // send while a request is outstanding
        add_row(make_input(CMD_SEND, 32'h0000_1234, 32'h0, 1'b0), 1'b1, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_ACK, 32'hFFFF_FFFF, 32'h0, 1'b0), 1'b1, 2,
                make_event(EV_CONNECTED, 32'hFFFF_FFFF, 32'd0, 16'h0, 1'b0),
                make_event(EV_ACK_OK, 32'hFFFF_FFFF, 32'd0, 16'h0, 1'b1));
        add_row(make_input(CMD_SEND, 32'h0, 32'h0, 1'b0), 1'b1, 1,
                make_event(EV_SEND, 32'h0, 32'd1, 16'h0, 1'b1), NO_EVENT);
        add_row(make_input(CMD_ACK, 32'h0, 32'hFFFF_FFFF, 1'b0), 1'b1, 1,
                make_event(EV_ACK_UNKNOWN, 32'h0, 32'hFFFF_FFFF, 16'h0, 1'b1), NO_EVENT);
        // short timeout: failed read, resend, abandon with disconnect
        add_row(make_input(CMD_SEND, 32'h5555_AAAA, 32'h0, 1'b0), 1'b1, 1,
                make_event(EV_SEND, 32'h5555_AAAA, 32'd2, DIR_VERSION, 1'b1), NO_EVENT);
        add_row(make_input(CMD_ACK, 32'h5555_AAAA, 32'd2, 1'b1), 1'b1, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b0, 0, NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b0, 0, NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_ACK, 32'h5555_AAAA, 32'd2, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b0, 0, NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b1, 2,
                make_event(EV_DISCONNECTED, 32'h5555_AAAA, 32'd2, 16'h0, 1'b0),
                make_event(EV_ACK_TIMEOUT, 32'h5555_AAAA, 32'd2, 16'h0, 1'b1));
        add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b1, 0, NO_EVENT, NO_EVENT);
        // reconnect, then lose the link again
        add_row(make_input(CMD_SEND, 32'hAAAA_5555, 32'h0, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_ACK, 32'hAAAA_5555, 32'd3, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_SEND, 32'h0000_0001, 32'h0, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);
        for (i = 0; i < 4; i++)
            add_row(make_input(CMD_TICK, 32'h0, 32'h0, 1'b0), 1'b0, 0, NO_EVENT, NO_EVENT);
        // right sequence, wrong id
        add_row(make_input(CMD_SEND, 32'h0000_0007, 32'h0, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);
        add_row(make_input(CMD_ACK, 32'h0000_0008, 32'd5, 1'b0), 1'b0, 0,
                NO_EVENT, NO_EVENT);

        send_idle_pct = 36;
        recv_idle_pct = 54;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (i = 0; i < directed_rows.size(); i++) begin
            if (i == TIMED_ROWS_FROM) begin
                wait_quiet();
                apply_config(8'd2, 16'd2, 8'd1, DIR_VERSION);
            end
            row = directed_rows[i];
            offer_event(row.ev, row.typed, row.n, row.r0, row.r1);
        end

        // random phases over several settings
        run_phase(8'd3, 16'd3, 8'd2, 16'($urandom), 36, 54, 106, 1'b0);
        run_phase(8'd0, 16'd0, 8'd0, 16'hFFFF, 36, 54, 106, 1'b0);
        run_phase(8'd255, 16'd1, 8'd255, 16'h0000, 54, 36, 106, 1'b0);
        run_phase(8'd1, 16'hFFFF, 8'd3, 16'($urandom), 54, 36, 106, 1'b0);
        run_phase(8'd2, 16'd2, 8'd1, 16'($urandom), 0, 0, 106, 1'b1);

        // long run of abandoned requests: fail count saturates
        wait_quiet();
        apply_config(8'd0, 16'd1, 8'd255, 16'($urandom));
        offer_event(make_input(CMD_SEND, random_id(), $urandom, 1'b0), 1'b0, 0,
                    NO_EVENT, NO_EVENT);
        e = make_input(CMD_ACK, req_id, req_seq, 1'b0);
        offer_event(e, 1'b0, 0, NO_EVENT, NO_EVENT);
        repeat (256) begin
            offer_event(make_input(CMD_SEND, random_id(), $urandom,
                                   1'($urandom_range(1))),
                        1'b0, 0, NO_EVENT, NO_EVENT);
            offer_event(make_input(CMD_TICK, $urandom, $urandom, 1'($urandom_range(1))),
                        1'b0, 0, NO_EVENT, NO_EVENT);
        end

        wait_quiet();
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("stop_and_wait_request_client test passed");
        else
            $display("stop_and_wait_request_client test failed");
        $finish;
    end

endmodule
